// File: design/tpas_pkg.sv
// Shared constants for the touch poll averager: widths, register indexes,
// touch phase codes and register reset values. No dependencies.
package tpas_pkg;

  localparam int unsigned MAX_SAMPLES = 16;
  localparam int unsigned RAW_W       = 16;                    // raw sample width
  localparam int unsigned POS_W       = 10;                    // screen coordinate width
  localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W       = RAW_W + $clog2(MAX_SAMPLES);
  localparam int unsigned PROD_W      = RAW_W + POS_W;         // (raw - lo) * size
  localparam int unsigned DVD_W       = (PROD_W > SUM_W) ? PROD_W : SUM_W;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MIN_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MAX_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MIN_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_MAX_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd7;

  // touch phase / status codes
  localparam logic [1:0] PH_NO_TOUCH = 2'd0;
  localparam logic [1:0] PH_PRESSED  = 2'd1;
  localparam logic [1:0] PH_HOLD     = 2'd2;
  localparam logic [1:0] PH_RELEASED = 2'd3;

  // register reset values
  localparam logic [4:0]       RST_SAMPLE_COUNT  = 5'd16;
  localparam logic [4:0]       RST_MIN_SAMPLES   = 5'd4;
  localparam logic [RAW_W-1:0] RST_RAW_MIN_X     = 16'd1500;
  localparam logic [RAW_W-1:0] RST_RAW_MAX_X     = 16'd30000;
  localparam logic [RAW_W-1:0] RST_RAW_MIN_Y     = 16'd1800;
  localparam logic [RAW_W-1:0] RST_RAW_MAX_Y     = 16'd29000;
  localparam logic [POS_W-1:0] RST_SCREEN_WIDTH  = 10'd320;
  localparam logic [POS_W-1:0] RST_SCREEN_HEIGHT = 10'd240;

endpackage

// File: design/tpas_serial_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tpas_pkg for the dividend and divisor widths.
module tpas_serial_div import tpas_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DVD_W-1:0]  dividend_i,
  input  logic [RAW_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DVD_W-1:0]  quotient_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [RAW_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  dq_q, dq_d;        // dividend shifts out, quotient shifts in
  logic [RAW_W-1:0]  divisor_q, divisor_d;
  logic [RAW_W:0]    rem_sh, rem_sub;
  logic              ge;

  always_comb begin
    rem_sh    = {rem_q, dq_q[DVD_W-1]};
    rem_sub   = rem_sh - {1'b0, divisor_q};
    ge        = (rem_sh >= {1'b0, divisor_q});
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    dq_d      = dq_q;
    divisor_d = divisor_q;
    if (start_i) begin
      busy_d    = 1'b1;
      cnt_d     = STEP_W'(DVD_W);
      rem_d     = '0;
      dq_d      = dividend_i;
      divisor_d = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[RAW_W-1:0] : rem_sh[RAW_W-1:0];
      dq_d  = {dq_q[DVD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    dq_q      <= dq_d;
    divisor_q <= divisor_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

// File: design/tpas_serial_mul.sv
// Shift-and-add multiplier: one multiplier bit per cycle.
// Depends on tpas_pkg for operand and product widths.
module tpas_serial_mul import tpas_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAW_W-1:0]  a_i,
  input  logic [POS_W-1:0]  b_i,
  output logic              done_o,
  output logic [PROD_W-1:0] product_o
);

  localparam int unsigned STEP_W = $clog2(POS_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0] a_q, a_d;          // multiplicand, shifts left
  logic [POS_W-1:0]  b_q, b_d;          // multiplier, shifts right

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(POS_W);
      acc_d  = '0;
      a_d    = PROD_W'(a_i);
      b_d    = b_i;
    end else if (busy_q) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d   = {a_q[PROD_W-2:0], 1'b0};
      b_d   = {1'b0, b_q[POS_W-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

// File: design/touch_poll_average_scale_top.sv
// Touch poll averager top level: accumulation, phase tracking, sequencer.
// Depends on tpas_pkg, tpas_serial_div and tpas_serial_mul.
// Sequencing: a sample that does not end a poll is only accumulated. A poll end
// with too few samples goes straight to the output register; a valid poll runs
// the bit-serial divider (26 steps, used twice per axis) and the 10-step
// multiplier, axes done one after the other.
// Throughput: one request at a time while a poll end is being worked out.
// Reset (async, active low): registers at defaults, phase no_touch, sums clear.
module touch_poll_average_scale_top import tpas_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // sample channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [RAW_W-1:0]      sample_x_i,
  input  logic [RAW_W-1:0]      sample_y_i,
  input  logic                  pen_up_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [POS_W-1:0]      pos_x_o,
  output logic [POS_W-1:0]      pos_y_o,
  output logic [1:0]            touch_status_o,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;  // taking samples
  localparam logic [2:0] ST_LOAD   = 3'd1;  // start sum / taken for current axis
  localparam logic [2:0] ST_AVG    = 3'd2;  // averaging divide running
  localparam logic [2:0] ST_CLAMP  = 3'd3;  // clamp to window, start multiply
  localparam logic [2:0] ST_MUL    = 3'd4;  // scale multiply running
  localparam logic [2:0] ST_SCALE  = 3'd5;  // divide by span running
  localparam logic [2:0] ST_FINISH = 3'd6;  // hand result to output register

  // configuration registers
  logic [4:0]       sample_count_q, min_samples_q;
  logic [RAW_W-1:0] raw_min_x_q, raw_max_x_q, raw_min_y_q, raw_max_y_q;
  logic [POS_W-1:0] screen_width_q, screen_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q  <= RST_SAMPLE_COUNT;
      min_samples_q   <= RST_MIN_SAMPLES;
      raw_min_x_q     <= RST_RAW_MIN_X;
      raw_max_x_q     <= RST_RAW_MAX_X;
      raw_min_y_q     <= RST_RAW_MIN_Y;
      raw_max_y_q     <= RST_RAW_MAX_Y;
      screen_width_q  <= RST_SCREEN_WIDTH;
      screen_height_q <= RST_SCREEN_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SAMPLE_COUNT:  sample_count_q  <= cfg_data_i[4:0];
        CFG_MIN_SAMPLES:   min_samples_q   <= cfg_data_i[4:0];
        CFG_RAW_MIN_X:     raw_min_x_q     <= cfg_data_i;
        CFG_RAW_MAX_X:     raw_max_x_q     <= cfg_data_i;
        CFG_RAW_MIN_Y:     raw_min_y_q     <= cfg_data_i;
        CFG_RAW_MAX_Y:     raw_max_y_q     <= cfg_data_i;
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i[POS_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective limits: sample_count in 1..MAX_SAMPLES, min_samples at least 1
  logic [4:0] limit, need;
  always_comb begin
    limit = sample_count_q;
    if (sample_count_q == 5'd0) limit = 5'd1;
    else if (sample_count_q > 5'(MAX_SAMPLES)) limit = 5'(MAX_SAMPLES);
    need = (min_samples_q == 5'd0) ? 5'd1 : min_samples_q;
  end

  // state
  logic [2:0]       state_q, state_d;
  logic             axis_q, axis_d;           // 0: X, 1: Y
  logic [1:0]       phase_q, phase_d;
  logic [1:0]       status_q, status_d;       // status of the poll in flight
  logic [SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CNT_W-1:0] taken_q, taken_d;
  logic [POS_W-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic             out_valid_q, out_valid_d;
  logic [POS_W-1:0] out_x_q, out_x_d, out_y_q, out_y_d;
  logic [1:0]       out_st_q, out_st_d;
  logic [RAW_W-1:0] avg_q, avg_d;

  // arithmetic units
  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dividend, div_quot;
  logic [RAW_W-1:0]  div_divisor;
  logic              mul_start, mul_done;
  logic [RAW_W-1:0]  mul_a;
  logic [POS_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_prod;

  tpas_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  tpas_serial_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  // per-axis calibration selection
  logic [RAW_W-1:0] lo, hi, clamped, span;
  logic [POS_W-1:0] size;
  logic             span_ok;
  always_comb begin
    lo      = axis_q ? raw_min_y_q : raw_min_x_q;
    hi      = axis_q ? raw_max_y_q : raw_max_x_q;
    size    = axis_q ? screen_height_q : screen_width_q;
    span_ok = (hi > lo);
    span    = hi - lo;
    clamped = avg_q;
    if (avg_q < lo) clamped = lo;
    else if (avg_q > hi) clamped = hi;
  end

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] taken_inc;
  logic             poll_end;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_q && out_ready_i;
  assign taken_inc  = taken_q + 1'b1;

  always_comb begin
    state_d      = state_q;
    axis_d       = axis_q;
    phase_d      = phase_q;
    status_d     = status_q;
    sum_x_d      = sum_x_q;
    sum_y_d      = sum_y_q;
    taken_d      = taken_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    out_valid_d  = out_acc ? 1'b0 : out_valid_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    out_st_d     = out_st_q;
    avg_d        = avg_q;
    div_start    = 1'b0;
    div_dividend = DVD_W'(axis_q ? sum_y_q : sum_x_q);
    div_divisor  = RAW_W'(taken_q);
    mul_start    = 1'b0;
    mul_a        = clamped - lo;
    mul_b        = size;
    poll_end     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (pen_up_i) begin
            poll_end = 1'b1;
          end else begin
            sum_x_d  = sum_x_q + SUM_W'(sample_x_i);
            sum_y_d  = sum_y_q + SUM_W'(sample_y_i);
            taken_d  = taken_inc;
            poll_end = (5'(taken_inc) >= limit);
          end
          if (poll_end) begin
            axis_d = 1'b0;
            if (5'(taken_d) < need) begin
              // too few samples: repeat previous position
              status_d = (phase_q == PH_NO_TOUCH) ? PH_NO_TOUCH : PH_RELEASED;
              phase_d  = PH_NO_TOUCH;
              state_d  = ST_FINISH;
            end else begin
              case (phase_q)
                PH_NO_TOUCH, PH_PRESSED: begin
                  status_d = PH_PRESSED;
                  phase_d  = PH_HOLD;
                end
                PH_RELEASED: begin
                  status_d = PH_RELEASED;
                  phase_d  = PH_NO_TOUCH;
                end
                default: status_d = PH_HOLD;
              endcase
              state_d = ST_LOAD;
            end
          end
        end
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_d   = ST_AVG;
      end
      ST_AVG: begin
        if (div_done) begin
          avg_d   = div_quot[RAW_W-1:0];
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (span_ok) begin
          mul_start = 1'b1;
          state_d   = ST_MUL;
        end else begin
          // zero or inverted span: coordinate is 0
          if (axis_q) prev_y_d = '0;
          else        prev_x_d = '0;
          axis_d  = 1'b1;
          state_d = axis_q ? ST_FINISH : ST_LOAD;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_start    = 1'b1;
          div_dividend = DVD_W'(mul_prod);
          div_divisor  = span;
          state_d      = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (div_done) begin
          if (axis_q) prev_y_d = div_quot[POS_W-1:0];
          else        prev_x_d = div_quot[POS_W-1:0];
          axis_d  = 1'b1;
          state_d = axis_q ? ST_FINISH : ST_LOAD;
        end
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_x_d     = prev_x_q;
          out_y_d     = prev_y_q;
          out_st_d    = status_q;
          sum_x_d     = '0;
          sum_y_d     = '0;
          taken_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      phase_q     <= PH_NO_TOUCH;
      status_q    <= PH_NO_TOUCH;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      taken_q     <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      phase_q     <= phase_d;
      status_q    <= status_d;
      sum_x_q     <= sum_x_d;
      sum_y_q     <= sum_y_d;
      taken_q     <= taken_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_q  <= out_x_d;
    out_y_q  <= out_y_d;
    out_st_q <= out_st_d;
    avg_q    <= avg_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pos_x_o        = out_x_q;
  assign pos_y_o        = out_y_q;
  assign touch_status_o = out_st_q;

endmodule

// File: tb/sv/touch_report_checker.sv
// Checker for the touch poll averager: watches the sample, result and register
// ports, predicts each touch report and compares it with what the block gives.
// Depends on tpas_pkg.
module touch_report_checker import tpas_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [RAW_W-1:0]      sample_x_i,
  input  logic [RAW_W-1:0]      sample_y_i,
  input  logic                  pen_up_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [POS_W-1:0]      pos_x_i,
  input  logic [POS_W-1:0]      pos_y_i,
  input  logic [1:0]            touch_status_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [1:0]       touch_status;
  } touch_report_t;

  touch_report_t expected_reports [$];

  // register copies
  logic [4:0]       poll_len_reg;
  logic [4:0]       min_valid_reg;
  logic [RAW_W-1:0] cal_min_x, cal_max_x, cal_min_y, cal_max_y;
  logic [POS_W-1:0] screen_w, screen_h;

  // poll state
  logic [1:0]       phase;
  logic [SUM_W-1:0] acc_x, acc_y;
  logic [CNT_W-1:0] n_taken;
  logic [POS_W-1:0] last_x, last_y;

  int mismatches;
  int checked;

  assign fail_count_o = mismatches;
  assign checked_o    = checked;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns touch report mismatch: %s got %0d expected %0d",
             $realtime, what, got, want);
    mismatches++;
  endtask

  // clamp to the calibration window, then scale to the screen
  function automatic logic [POS_W-1:0] map_to_screen(input logic [RAW_W-1:0] avg,
      input logic [RAW_W-1:0] lo, input logic [RAW_W-1:0] hi,
      input logic [POS_W-1:0] size);
    logic [RAW_W-1:0]  r;
    logic [PROD_W-1:0] prod;
    r = avg;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    if (hi <= lo) return '0;
    prod = (r - lo) * size;
    return POS_W'(prod / PROD_W'(hi - lo));
  endfunction

  task automatic accumulate_sample(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y,
                                   input logic up);
    int unsigned   limit, need;
    touch_report_t rpt;
    limit = (poll_len_reg == 0) ? 1 :
            (poll_len_reg > MAX_SAMPLES) ? MAX_SAMPLES : poll_len_reg;
    need  = (min_valid_reg == 0) ? 1 : min_valid_reg;
    if (!up) begin
      acc_x   += SUM_W'(x);
      acc_y   += SUM_W'(y);
      n_taken += 1'b1;
    end
    if (up || n_taken >= limit) begin
      if (n_taken < need) begin
        rpt.touch_status = (phase == PH_NO_TOUCH) ? PH_NO_TOUCH : PH_RELEASED;
        phase = PH_NO_TOUCH;
      end else begin
        last_x = map_to_screen(RAW_W'(acc_x / n_taken), cal_min_x, cal_max_x, screen_w);
        last_y = map_to_screen(RAW_W'(acc_y / n_taken), cal_min_y, cal_max_y, screen_h);
        case (phase)
          PH_NO_TOUCH, PH_PRESSED: begin
            rpt.touch_status = PH_PRESSED;
            phase = PH_HOLD;
          end
          PH_RELEASED: begin
            rpt.touch_status = PH_RELEASED;
            phase = PH_NO_TOUCH;
          end
          default: rpt.touch_status = PH_HOLD;
        endcase
      end
      rpt.pos_x = last_x;
      rpt.pos_y = last_y;
      expected_reports.push_back(rpt);
      acc_x   = '0;
      acc_y   = '0;
      n_taken = '0;
    end
  endtask

  task automatic check_report();
    touch_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch("unexpected result, status", touch_status_i, 0);
    end else begin
      want = expected_reports.pop_front();
      if (pos_x_i != want.pos_x) report_mismatch("pos_x", pos_x_i, want.pos_x);
      if (pos_y_i != want.pos_y) report_mismatch("pos_y", pos_y_i, want.pos_y);
      if (touch_status_i != want.touch_status)
        report_mismatch("touch_status", touch_status_i, want.touch_status);
      checked++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_len_reg  = RST_SAMPLE_COUNT;
      min_valid_reg = RST_MIN_SAMPLES;
      cal_min_x     = RST_RAW_MIN_X;
      cal_max_x     = RST_RAW_MAX_X;
      cal_min_y     = RST_RAW_MIN_Y;
      cal_max_y     = RST_RAW_MAX_Y;
      screen_w      = RST_SCREEN_WIDTH;
      screen_h      = RST_SCREEN_HEIGHT;
      phase         = PH_NO_TOUCH;
      acc_x         = '0;
      acc_y         = '0;
      n_taken       = '0;
      last_x        = '0;
      last_y        = '0;
      mismatches    = 0;
      checked       = 0;
      expected_reports.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SAMPLE_COUNT:  poll_len_reg  = cfg_data_i[4:0];
          CFG_MIN_SAMPLES:   min_valid_reg = cfg_data_i[4:0];
          CFG_RAW_MIN_X:     cal_min_x     = cfg_data_i[RAW_W-1:0];
          CFG_RAW_MAX_X:     cal_max_x     = cfg_data_i[RAW_W-1:0];
          CFG_RAW_MIN_Y:     cal_min_y     = cfg_data_i[RAW_W-1:0];
          CFG_RAW_MAX_Y:     cal_max_y     = cfg_data_i[RAW_W-1:0];
          CFG_SCREEN_WIDTH:  screen_w      = cfg_data_i[POS_W-1:0];
          CFG_SCREEN_HEIGHT: screen_h      = cfg_data_i[POS_W-1:0];
          default: ;
        endcase
      end
      // results leave before a new poll end can be queued
      if (out_valid_i && out_ready_i) check_report();
      if (in_valid_i && in_ready_i) accumulate_sample(sample_x_i, sample_y_i, pen_up_i);
      pending_o <= expected_reports.size();
    end
  end

endmodule

// File: tb/sv/touch_poll_average_scale_top_tb.sv
// Testbench top for the touch poll averager: clock, reset, sample requests,
// register settings, result-side stalls and the verdict.
// Depends on tpas_pkg, touch_poll_average_scale_top and touch_report_checker.
module touch_poll_average_scale_top_tb;
  import tpas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF_CYCLES = 800;   // long receiver hold-off, fills the block
  localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no request or result moving
  localparam int DRAIN_CYCLES    = 150;   // final wait after the last expected result
  localparam int NUM_PHASES      = 8;
  localparam int PHASE_REQUESTS  = 50;

  typedef struct {
    logic [4:0]       count;
    logic [4:0]       min_cnt;
    logic [RAW_W-1:0] min_x, max_x, min_y, max_y;
    logic [POS_W-1:0] width, height;
  } poll_setup_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [RAW_W-1:0]      sample_x_i   = '0;
  logic [RAW_W-1:0]      sample_y_i   = '0;
  logic                  pen_up_i     = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [POS_W-1:0]      pos_x_o;
  logic [POS_W-1:0]      pos_y_o;
  logic [1:0]            touch_status_o;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;

  int fail_count, pending, checked;

  // idle percentages, read by the sender task and the result sink
  int idle_pct  = 0;
  int stall_pct = 0;
  logic hold_off_req = 1'b0;

  int sent = 0;
  int settings_applied = 0;
  poll_setup_t cur_setup;

  int idle_by_mode  [4] = '{0, 67, 0, 35};
  int stall_by_mode [4] = '{0, 0, 67, 35};

  touch_poll_average_scale_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_x_i     (sample_x_i),
    .sample_y_i     (sample_y_i),
    .pen_up_i       (pen_up_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .touch_status_o (touch_status_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  touch_report_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .sample_x_i     (sample_x_i),
    .sample_y_i     (sample_y_i),
    .pen_up_i       (pen_up_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pos_x_i        (pos_x_o),
    .pos_y_i        (pos_y_o),
    .touch_status_i (touch_status_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // Result sink. Ready is redrawn every cycle from stall_pct. A hold-off
  // request drops ready for a long stretch, counted here, while the sender
  // keeps offering samples so the block backs up into its input.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: counts cycles in which nothing moves on either channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("touch_poll_average_scale_top regression: fail");
    $finish;
  end

  // Effective poll length as the block sees it: 0 acts as 1, caps at 16.
  function automatic int poll_length(input logic [4:0] c);
    return (c == 0) ? 1 : (c > MAX_SAMPLES) ? MAX_SAMPLES : int'(c);
  endfunction

  // Sample near a touch center; now and then a fully random reading.
  function automatic logic [RAW_W-1:0] near(input logic [RAW_W-1:0] c);
    int v;
    if ($urandom_range(15) == 0) return RAW_W'($urandom);
    v = int'(c) + int'($urandom_range(512)) - 256;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return RAW_W'(v);
  endfunction

  function automatic poll_setup_t pick_setup(input int p);
    poll_setup_t s;
    // random window, inverted or flat about a fifth of the time
    s.count   = 5'($urandom_range(31));
    s.min_cnt = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                         : 5'($urandom_range(poll_length(s.count)));
    s.min_x   = RAW_W'($urandom);
    s.max_x   = ($urandom_range(4) == 0) ? RAW_W'($urandom_range(s.min_x))
                                         : RAW_W'($urandom_range(65535, s.min_x));
    s.min_y   = RAW_W'($urandom);
    s.max_y   = ($urandom_range(4) == 0) ? RAW_W'($urandom_range(s.min_y))
                                         : RAW_W'($urandom_range(65535, s.min_y));
    s.width   = POS_W'($urandom_range(1023));
    s.height  = POS_W'($urandom_range(1023));
    case (p)
      0: s = '{RST_SAMPLE_COUNT, RST_MIN_SAMPLES, RST_RAW_MIN_X, RST_RAW_MAX_X,
               RST_RAW_MIN_Y, RST_RAW_MAX_Y, RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT};
      // count far above the cap, full window, largest screen
      1: s = '{5'd31, 5'd16, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 10'd1023, 10'd1023};
      // one sample per poll, tiniest screen
      2: begin
        s.count   = 5'd1;
        s.min_cnt = 5'd1;
        s.width   = 10'd1;
        s.height  = 10'd1;
      end
      3: begin
        s.count   = 5'd17;
        s.min_cnt = 5'd0;
      end
      default: ;
    endcase
    return s;
  endfunction

  // Drop valid, wait until every expected result has come, then let the
  // block finish any sample still in flight.
  task automatic settle(input int extra);
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Write all eight registers on back-to-back cycles.
  task automatic apply_setup(input poll_setup_t s);
    logic [CFG_IDX_W-1:0]  idx [8];
    logic [CFG_DATA_W-1:0] val [8];
    idx = '{CFG_SAMPLE_COUNT, CFG_MIN_SAMPLES, CFG_RAW_MIN_X, CFG_RAW_MAX_X,
            CFG_RAW_MIN_Y, CFG_RAW_MAX_Y, CFG_SCREEN_WIDTH, CFG_SCREEN_HEIGHT};
    val = '{CFG_DATA_W'(s.count), CFG_DATA_W'(s.min_cnt), s.min_x, s.max_x,
            s.min_y, s.max_y, CFG_DATA_W'(s.width), CFG_DATA_W'(s.height)};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cur_setup = s;
    settings_applied++;
  endtask

  // One sample request. Valid stays high between back-to-back requests and
  // is only dropped when an idle gap is drawn.
  task automatic send_sample(input logic [RAW_W-1:0] x, input logic [RAW_W-1:0] y,
                             input logic up);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i <= 1'b1;
    sample_x_i <= x;
    sample_y_i <= y;
    pen_up_i   <= up;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
  endtask

  // A touch gesture: a few full polls around one spot, sometimes a poll cut
  // short by pen-up, then the pen lifts (its payload is junk and ignored).
  task automatic run_gesture();
    int polls, limit, n;
    logic [RAW_W-1:0] cx, cy;
    limit = poll_length(cur_setup.count);
    cx    = RAW_W'($urandom);
    cy    = RAW_W'($urandom);
    polls = int'($urandom_range(3));
    for (int p = 0; p < polls; p++) begin
      n = ($urandom_range(5) == 0) ? int'($urandom_range(limit)) : limit;
      for (int k = 0; k < n; k++) send_sample(near(cx), near(cy), 1'b0);
      if (n < limit) send_sample(RAW_W'($urandom), RAW_W'($urandom), 1'b1);
    end
    send_sample(RAW_W'($urandom), RAW_W'($urandom), 1'b1);
  endtask

  initial begin : stimulus
    int phase_start;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle(4);

    // Directed, reset settings. Empty poll ended by pen-up; then a short
    // poll with extreme samples that stays below the minimum.
    send_sample(16'hFFFF, 16'hFFFF, 1'b1);
    send_sample(16'h0000, 16'h0000, 1'b0);
    send_sample(16'hFFFF, 16'hFFFF, 1'b0);
    send_sample(16'd100, 16'd200, 1'b0);
    send_sample(16'h0000, 16'h0000, 1'b1);

    // Two-sample polls on a full-size screen: clamp at the low edge (press),
    // clamp at the far edge (hold, coordinate equals the screen size),
    // release, too-short poll, fresh press.
    settle(4);
    apply_setup('{5'd2, 5'd2, 16'd1000, 16'd60000, 16'd2000, 16'd50000,
                  10'd1023, 10'd1023});
    send_sample(16'h0000, 16'h0000, 1'b0);
    send_sample(16'h0000, 16'h0000, 1'b0);
    send_sample(16'hFFFF, 16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 16'hFFFF, 1'b0);
    send_sample(16'h1234, 16'h4321, 1'b1);
    send_sample(16'd30000, 16'd30000, 1'b0);
    send_sample(16'd0, 16'd0, 1'b1);
    send_sample(16'd30000, 16'd20000, 1'b0);
    send_sample(16'd31001, 16'd20001, 1'b0);

    // Count and minimum of zero act as one; inverted X window, flat Y
    // window, zero screen width: both coordinates come out zero.
    settle(4);
    apply_setup('{5'd0, 5'd0, 16'd40000, 16'd100, 16'd5000, 16'd5000, 10'd0, 10'd1});
    send_sample(16'd12345, 16'd54321, 1'b0);
    send_sample(16'd0, 16'd0, 1'b1);

    // Minimum above the poll length: every poll is invalid.
    settle(4);
    apply_setup('{5'd3, 5'd5, RST_RAW_MIN_X, RST_RAW_MAX_X, RST_RAW_MIN_Y, RST_RAW_MAX_Y,
                  RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT});
    send_sample(16'd5000, 16'd6000, 1'b0);
    send_sample(16'd5100, 16'd6100, 1'b0);
    send_sample(16'd5200, 16'd6200, 1'b0);

    // Random phases: each one picks a register setting and an idle pattern;
    // the first also holds the receiver off for a long stretch.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle(4);
      apply_setup(pick_setup(p));
      idle_pct  = idle_by_mode[p % 4];
      stall_pct = stall_by_mode[p % 4];
      if (p == 0) hold_off_req = 1'b1;
      phase_start = sent;
      while (sent - phase_start < PHASE_REQUESTS) run_gesture();
    end

    settle(DRAIN_CYCLES);
    $display("covered %0d sample requests under %0d register settings, %0d results checked",
             sent, settings_applied, checked);
    $display("idle patterns: none, sender 67%%, receiver 67%%, both 35%%, %s %0d cycles",
             "plus one hold-off of", HOLD_OFF_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("touch_poll_average_scale_top regression: pass");
    end else begin
      $display("touch_poll_average_scale_top regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/tpas_pkg.sv
design/tpas_serial_div.sv
design/tpas_serial_mul.sv
design/touch_poll_average_scale_top.sv
tb/sv/touch_report_checker.sv
tb/sv/touch_poll_average_scale_top_tb.sv
